@@ sv/wia_pkg.sv @@
// shared types, constants and helper functions for the wide integer alu
// no dependencies; imported by every module of the block
`default_nettype none

package wia_pkg;

    localparam int DATA_W = 64;
    localparam int HALF_W = 32;
    localparam int CNT_W  = 7;
    localparam int SC_W   = 8;

    localparam logic [CNT_W-1:0] SHIFT_LIMIT = CNT_W'(DATA_W);

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_MUL = 3'd2,
        FN_DIV = 3'd3,
        FN_MOD = 3'd4,
        FN_SHL = 3'd5,
        FN_SHR = 3'd6,
        FN_CMP = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_DONE
    } t_state;

    // sequencer commands to the datapath and output stage
    typedef struct packed {
        logic load;
        logic step;
        logic done;
    } t_ctl;

    // shift magnitude, direction folded out, clamped to the word width
    function automatic logic [CNT_W-1:0] f_shift_mag(input logic [SC_W-1:0] sc);
        logic [SC_W-1:0] mag;
        mag = sc[SC_W-1] ? (~sc + SC_W'(1)) : sc;
        if (mag > SC_W'(DATA_W)) begin
            return SHIFT_LIMIT;
        end
        return mag[CNT_W-1:0];
    endfunction

    // number of serial steps an operation needs
    function automatic logic [CNT_W-1:0] f_step_count(
        input t_func           func,
        input logic            b_low_zero,
        input logic [SC_W-1:0] sc
    );
        logic [CNT_W-1:0] n;
        case (func)
            FN_MUL: begin
                n = CNT_W'(HALF_W);
            end
            FN_DIV, FN_MOD: begin
                n = b_low_zero ? '0 : CNT_W'(DATA_W);
            end
            FN_SHL, FN_SHR: begin
                n = f_shift_mag(sc);
            end
            default: begin
                n = CNT_W'(DATA_W);
            end
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

@@ sv/wide_integer_alu_64.sv @@
// serial steps per transaction, one bit-serial step per cycle in the datapath: 64 for
//   add, sub, compare, div and mod, 32 for mul, |shift_count| clamped to 64 for shifts,
//   0 for div or mod by zero
// transactions: one at a time; a new one is taken only once the result enters the output register
// reset: i_rst_n synchronous, active low; clears the sequencer and the output valid
`default_nettype none

module wide_integer_alu_64 (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input channel
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [2:0]                 i_func,
    input  wire logic [wia_pkg::DATA_W-1:0] i_operand_a,
    input  wire logic [wia_pkg::DATA_W-1:0] i_operand_b,
    input  wire logic [wia_pkg::SC_W-1:0]   i_shift_count,
    // output channel
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [wia_pkg::DATA_W-1:0]      o_result,
    output logic                            o_equal,
    output logic                            o_greater,
    output logic                            o_less,
    output logic                            o_div_by_zero
);
    import wia_pkg::*;

    t_ctl              ctl;
    t_func             func;
    logic [CNT_W-1:0]  step_count;
    logic              out_free;

    logic [DATA_W-1:0] dp_result;
    logic              dp_equal, dp_greater, dp_less, dp_dz;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_result;
    logic              r_equal, r_greater, r_less, r_dz;

    assign func = t_func'(i_func);

    // how many serial steps the offered transaction will take
    assign step_count = f_step_count(func, i_operand_b[HALF_W-1:0] == '0, i_shift_count);

    // output register can take a new result when empty or being drained
    assign out_free = ~r_out_valid | i_ready;

    wia_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_out_free   (out_free),
        .i_step_count (step_count),
        .o_ctl        (ctl),
        .o_in_ready   (o_ready)
    );

    wia_datapath u_datapath (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_func        (func),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_shift_count (i_shift_count),
        .o_result      (dp_result),
        .o_equal       (dp_equal),
        .o_greater     (dp_greater),
        .o_less        (dp_less),
        .o_div_by_zero (dp_dz)
    );

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, held while the transaction is stalled
    always_ff @(posedge i_clk) begin
        if (ctl.done) begin
            r_result  <= dp_result;
            r_equal   <= dp_equal;
            r_greater <= dp_greater;
            r_less    <= dp_less;
            r_dz      <= dp_dz;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result      = r_result;
    assign o_equal       = r_equal;
    assign o_greater     = r_greater;
    assign o_less        = r_less;
    assign o_div_by_zero = r_dz;

endmodule

`default_nettype wire

@@ sv/wia_ctrl.sv @@
// sequencer: accepts a transaction, counts the serial steps, hands over the result
// depends on wia_pkg for the state type, the command struct and the counter width
`default_nettype none

module wia_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_out_free,
    input  wire logic [wia_pkg::CNT_W-1:0] i_step_count,
    output wia_pkg::t_ctl                  o_ctl,
    output logic                           o_in_ready
);
    import wia_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_step_count == '0) ? ST_DONE : ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        n_cnt      = r_cnt;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
                n_cnt      = i_step_count;
            end
            ST_BUSY: begin
                o_ctl.step = 1'b1;
                n_cnt      = r_cnt - CNT_W'(1);
            end
            ST_DONE: begin
                o_ctl.done = i_out_free;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_BUSY |-> r_cnt != '0)
        else $error("busy with no steps left");

    a_zero_steps_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load && i_step_count == '0 |=> r_state == ST_DONE)
        else $error("zero-step transaction did not finish at once");

    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_BUSY && r_cnt == CNT_W'(1) |=> r_state == ST_DONE)
        else $error("last step did not lead to done");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctl.load, o_ctl.step, o_ctl.done}))
        else $error("more than one command at a time");

endmodule

`default_nettype wire

@@ sv/wia_datapath.sv @@
// serial datapath: bit-serial add, subtract and compare, shift-add multiply,
// restoring divide and single-bit shifts; depends on wia_pkg
`default_nettype none

module wia_datapath (
    input  wire logic                       i_clk,
    input  wire wia_pkg::t_ctl              i_ctl,
    input  wire wia_pkg::t_func             i_func,
    input  wire logic [wia_pkg::DATA_W-1:0] i_operand_a,
    input  wire logic [wia_pkg::DATA_W-1:0] i_operand_b,
    input  wire logic [wia_pkg::SC_W-1:0]   i_shift_count,
    output logic [wia_pkg::DATA_W-1:0]      o_result,
    output logic                            o_equal,
    output logic                            o_greater,
    output logic                            o_less,
    output logic                            o_div_by_zero
);
    import wia_pkg::*;

    t_func             r_op;
    logic [DATA_W-1:0] r_a, n_a;
    logic [DATA_W-1:0] r_b, n_b;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [HALF_W-1:0] r_rem, n_rem;
    logic              r_carry, n_carry;
    logic              r_nz, n_nz;
    logic              r_dz;
    logic              r_left;

    logic              bb, sum;
    logic [HALF_W:0]   trial, diff;
    logic              ge;

    always_comb begin
        bb    = (r_op == FN_ADD) ? r_b[0] : ~r_b[0];
        sum   = r_a[0] ^ bb ^ r_carry;
        trial = {r_rem, r_a[DATA_W-1]};
        diff  = trial - {1'b0, r_b[HALF_W-1:0]};
        ge    = ~diff[HALF_W];

        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_carry = r_carry;
        n_nz    = r_nz;
        case (r_op)
            FN_ADD, FN_SUB, FN_CMP: begin
                // lsb first; the sum bits fill the operand register from the top
                n_a     = {sum, r_a[DATA_W-1:1]};
                n_b     = {1'b0, r_b[DATA_W-1:1]};
                n_carry = (r_a[0] & bb) | (r_a[0] & r_carry) | (bb & r_carry);
                n_nz    = r_nz | sum;
            end
            FN_MUL: begin
                // msb first over the low half of b
                n_acc = {r_acc[DATA_W-2:0], 1'b0} + (r_b[HALF_W-1] ? r_a : '0);
                n_b   = {r_b[DATA_W-2:0], 1'b0};
            end
            FN_DIV, FN_MOD: begin
                // quotient bits enter the dividend register from the bottom
                n_rem = ge ? diff[HALF_W-1:0] : trial[HALF_W-1:0];
                n_a   = {r_a[DATA_W-2:0], ge};
            end
            FN_SHL, FN_SHR: begin
                n_a = r_left ? {r_a[DATA_W-2:0], 1'b0} : {1'b0, r_a[DATA_W-1:1]};
            end
            default: begin
                n_a = r_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op    <= i_func;
            r_a     <= i_operand_a;
            r_b     <= i_operand_b;
            r_acc   <= '0;
            r_rem   <= '0;
            r_carry <= (i_func == FN_SUB) || (i_func == FN_CMP);
            r_nz    <= 1'b0;
            r_dz    <= ((i_func == FN_DIV) || (i_func == FN_MOD))
                       && (i_operand_b[HALF_W-1:0] == '0);
            r_left  <= (i_func == FN_SHL) ^ i_shift_count[SC_W-1];
        end else if (i_ctl.step) begin
            r_a     <= n_a;
            r_b     <= n_b;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_carry <= n_carry;
            r_nz    <= n_nz;
        end
    end

    always_comb begin
        o_result      = '0;
        o_equal       = 1'b0;
        o_greater     = 1'b0;
        o_less        = 1'b0;
        o_div_by_zero = r_dz;
        case (r_op)
            FN_MUL: begin
                o_result = r_acc;
            end
            FN_DIV: begin
                o_result = r_dz ? '0 : r_a;
            end
            FN_MOD: begin
                o_result = r_dz ? '0 : {{(DATA_W-HALF_W){1'b0}}, r_rem};
            end
            FN_CMP: begin
                // carry out of a - b set means no borrow, a >= b
                o_equal   = ~r_nz;
                o_greater = r_carry & r_nz;
                o_less    = ~r_carry;
            end
            default: begin
                o_result = r_a;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ tb/sv/wia_result_checker.sv @@
// result checker for the wide integer alu: watches both channels and predicts results
// depends on wia_pkg for widths and the operation codes
module wia_result_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_ready,
    input  wire logic [2:0]                 i_func,
    input  wire logic [wia_pkg::DATA_W-1:0] i_operand_a,
    input  wire logic [wia_pkg::DATA_W-1:0] i_operand_b,
    input  wire logic [wia_pkg::SC_W-1:0]   i_shift_count,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_ready,
    input  wire logic [wia_pkg::DATA_W-1:0] i_result,
    input  wire logic                       i_equal,
    input  wire logic                       i_greater,
    input  wire logic                       i_less,
    input  wire logic                       i_div_by_zero,
    output int                              o_fail_count,
    output int                              o_pending
);
    import wia_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              eq;
        logic              gt;
        logic              lt;
        logic              dz;
    } t_alu_result;

    t_alu_result alu_results_due[$];
    int          mismatches = 0;

    function automatic t_alu_result predict_alu_result(
        input t_func             fn,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [SC_W-1:0]   sc
    );
        t_alu_result       r;
        logic [DATA_W-1:0] b_low;
        logic [SC_W:0]     mag;
        logic              to_left;
        r = '0;
        b_low = {{HALF_W{1'b0}}, b[HALF_W-1:0]};
        // negative count: magnitude 1..128, direction flipped
        mag = sc[SC_W-1] ? ({1'b1, {SC_W{1'b0}}} - {1'b0, sc}) : {1'b0, sc};
        to_left = (fn == FN_SHL) ^ sc[SC_W-1];
        case (fn)
            FN_ADD: begin
                r.value = a + b;
            end
            FN_SUB: begin
                r.value = a - b;
            end
            FN_MUL: begin
                r.value = a * b_low;
            end
            FN_DIV, FN_MOD: begin
                if (b_low == '0) begin
                    r.dz = 1'b1;
                end else begin
                    r.value = (fn == FN_DIV) ? a / b_low : a % b_low;
                end
            end
            FN_SHL, FN_SHR: begin
                if (mag < DATA_W) begin
                    r.value = to_left ? a << mag : a >> mag;
                end
            end
            default: begin
                r.eq = (a == b);
                r.gt = (a > b);
                r.lt = (a < b);
            end
        endcase
        return r;
    endfunction

    task automatic note_failure(input string msg);
        if (mismatches < REPORT_MAX) begin
            $display("%0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            note_failure($sformatf("%s mismatch: expected %h, got %h", field, want, got));
        end
    endtask

    always @(posedge i_clk) begin
        t_alu_result want;
        if (!i_rst_n) begin
            alu_results_due.delete();
        end else begin
            // retire before predicting: a result never leaves in its own input cycle
            if (i_out_valid && i_out_ready) begin
                if (alu_results_due.size() == 0) begin
                    note_failure($sformatf("unexpected result %h", i_result));
                end else begin
                    want = alu_results_due.pop_front();
                    check_field("result", want.value, i_result);
                    check_field("equal", DATA_W'(want.eq), DATA_W'(i_equal));
                    check_field("greater", DATA_W'(want.gt), DATA_W'(i_greater));
                    check_field("less", DATA_W'(want.lt), DATA_W'(i_less));
                    check_field("div_by_zero", DATA_W'(want.dz), DATA_W'(i_div_by_zero));
                end
            end
            if (i_in_valid && i_in_ready) begin
                alu_results_due.push_back(predict_alu_result(t_func'(i_func), i_operand_a,
                                                             i_operand_b, i_shift_count));
            end
        end
        o_pending    <= alu_results_due.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/sv/tb.sv @@
// top of the wide integer alu testbench: clock, reset, stimulus, back-pressure and verdict
// depends on wia_pkg, wide_integer_alu_64 and wia_result_checker
module tb;
    import wia_pkg::*;

    // cycles with no transaction on either channel before the run is abandoned;
    // well beyond the slowest operation, to cover long random stalls
    localparam int QUIET_LIMIT  = 5000;
    // cycles to linger after the last result, longer than the slowest operation
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_ITEMS  = 100;
    localparam logic [HALF_W-1:0] HALF_MSB = 32'h8000_0000;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    logic [2:0]        i_func        = '0;
    logic [DATA_W-1:0] i_operand_a   = '0;
    logic [DATA_W-1:0] i_operand_b   = '0;
    logic [SC_W-1:0]   i_shift_count = '0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    logic [DATA_W-1:0] o_result;
    logic              o_equal;
    logic              o_greater;
    logic              o_less;
    logic              o_div_by_zero;

    int fail_count;
    int results_pending;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles       = 0;

    // per-phase idling: none, sender idle, receiver stalling, both
    int idle_pct_by_phase[4]  = '{0, 71, 0, 38};
    int stall_pct_by_phase[4] = '{0, 0, 71, 38};

    wide_integer_alu_64 uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_shift_count (i_shift_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result      (o_result),
        .o_equal       (o_equal),
        .o_greater     (o_greater),
        .o_less        (o_less),
        .o_div_by_zero (o_div_by_zero)
    );

    wia_result_checker result_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_func        (i_func),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_shift_count (i_shift_count),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_result      (o_result),
        .i_equal       (o_equal),
        .i_greater     (o_greater),
        .i_less        (o_less),
        .i_div_by_zero (o_div_by_zero),
        .o_fail_count  (fail_count),
        .o_pending     (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver back-pressure, redrawn every cycle from the current phase's stall percentage
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // watchdog: a run of cycles with no transaction on either side means a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // one input transaction; valid stays high from one item straight into the next
    // unless an idle gap is drawn, so it is never dropped and raised in one step
    task automatic push_op(input t_func fn, input logic [DATA_W-1:0] a,
                           input logic [DATA_W-1:0] b, input logic [SC_W-1:0] sc);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= fn;
        i_operand_a   <= a;
        i_operand_b   <= b;
        i_shift_count <= sc;
        // o_ready read here is the value sampled at this edge
        do begin
            @(posedge i_clk);
        end while (o_ready !== 1'b1);
    endtask

    // operand mix: corners, single bits, small values, half-word patterns, full noise
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        case ($urandom_range(7))
            0: begin
                v = '0;
            end
            1: begin
                v = '1;
            end
            2: begin
                v = DATA_W'(1) << $urandom_range(DATA_W - 1);
            end
            3: begin
                v = DATA_W'($urandom_range(255));
            end
            4: begin
                v = {{HALF_W{1'b0}}, HALF_W'($urandom)};
            end
            5: begin
                v = {HALF_W'($urandom), HALF_MSB};
            end
            default: begin
                v = {HALF_W'($urandom), HALF_W'($urandom)};
            end
        endcase
        return v;
    endfunction

    // shift counts: half uniform over the whole byte, half around the clamp edges
    function automatic logic [SC_W-1:0] pick_shift_count();
        logic [SC_W-1:0] c;
        if ($urandom_range(1) == 0) begin
            c = SC_W'($urandom_range(255));
        end else begin
            case ($urandom_range(10))
                0: c = 8'sd0;
                1: c = 8'sd1;
                2: c = 8'sd63;
                3: c = 8'sd64;
                4: c = 8'sd65;
                5: c = 8'sd127;
                6: c = -8'sd1;
                7: c = -8'sd63;
                8: c = -8'sd64;
                9: c = -8'sd65;
                default: c = -8'sd128;
            endcase
        end
        return c;
    endfunction

    task automatic push_random_op();
        t_func             fn;
        logic [DATA_W-1:0] b;
        fn = t_func'($urandom_range(7));
        b  = pick_operand();
        // divide and modulo see a zero divisor now and then, upper half left random
        if ((fn == FN_DIV || fn == FN_MOD) && $urandom_range(9) == 0) begin
            b[HALF_W-1:0] = '0;
        end
        push_op(fn, pick_operand(), b, pick_shift_count());
    endtask

    initial begin
        // synchronous reset held at the start of the run, once only
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners, no idling
        push_op(FN_ADD, '1, 64'd1, 8'sd0);                   // wraps to zero
        push_op(FN_ADD, '0, '0, -8'sd1);
        push_op(FN_SUB, '0, 64'd1, 8'sd0);                   // borrows through all bits
        push_op(FN_SUB, '1, '1, 8'sd0);
        push_op(FN_MUL, '1, 64'hFFFF_FFFF_FFFF_FFFF, 8'sd0); // upper half of b ignored
        push_op(FN_MUL, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_0000_0000, 8'sd0);
        push_op(FN_DIV, '1, 64'hFFFF_FFFF_0000_0000, 8'sd0); // zero divisor, high bits set
        push_op(FN_DIV, '1, 64'd1, 8'sd0);
        push_op(FN_DIV, '1, {32'hFFFF_FFFF, HALF_MSB}, 8'sd0);
        push_op(FN_MOD, 64'd12345, '0, 8'sd0);               // zero divisor
        push_op(FN_MOD, '1, 64'h0000_0000_FFFF_FFFF, 8'sd0);
        push_op(FN_SHL, 64'h8000_0000_0000_0001, '0, 8'sd0);
        push_op(FN_SHL, 64'd1, '0, 8'sd63);
        push_op(FN_SHL, '1, '0, 8'sd64);                     // at the clamp limit, everything out
        push_op(FN_SHL, '1, '0, 8'sd127);
        push_op(FN_SHL, '1, '0, -8'sd1);                     // negative turns it into a right shift
        push_op(FN_SHL, '1, '0, -8'sd128);
        push_op(FN_SHR, '1, '0, 8'sd1);
        push_op(FN_SHR, '1, '0, 8'sd64);
        push_op(FN_SHR, 64'd1, '0, -8'sd63);                 // reversed into a left shift
        push_op(FN_SHR, '1, '0, -8'sd128);
        push_op(FN_CMP, 64'hDEAD_BEEF_0000_0001, 64'hDEAD_BEEF_0000_0001, 8'sd0);
        push_op(FN_CMP, '1, '0, 8'sd0);
        push_op(FN_CMP, '0, '1, 8'sd0);
        push_op(FN_CMP, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 8'sd0);

        // random phases with different idling on each side
        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = idle_pct_by_phase[phase];
            receiver_stall_pct = stall_pct_by_phase[phase];
            repeat (PHASE_ITEMS) push_random_op();
        end

        // drain: stop sending, open the output side, wait for the last results
        i_valid            <= 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        @(posedge i_clk);
        while (results_pending != 0) begin
            @(posedge i_clk);
        end
        // linger so that any stray result is still caught
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && results_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
